>>> rtl/dlmb_pkg.sv
package dlmb_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int LAG_W      = 11;
  localparam int SLOT_W     = 3;
  localparam int CMD_W      = 2;
  localparam int ROW_W      = 24;
  localparam int COL_W      = 3;
  localparam int CNT_W      = 32;
  localparam int DEC_W      = 11;
  localparam int OFS_W      = 16;
  localparam int LCNT_W     = 4;
  localparam int BASE_W     = CNT_W + 1;
  localparam int IDX_W      = CNT_W + 3;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 1;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_DECIMATION = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_OFFSET = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LAG_COUNT  = 2'd2;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_PAD     = 2'd1,
    CMD_LAG     = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PREP   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  typedef struct packed {
    logic [ROW_W-1:0]    row_index;
    logic [COL_W-1:0]    column_index;
    logic [SAMPLE_W-1:0] value;
    logic                missing;
    logic                row_last;
  } elem_t;

endpackage

>>> rtl/dlmb_ram.sv
module dlmb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/dlmb_outq.sv
module dlmb_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dlmb_pkg::elem_t       push_elem,
  input  logic                  pop_ready,
  output logic                  head_valid,
  output dlmb_pkg::elem_t       head_elem,
  output logic [dlmb_pkg::OQ_AW:0] count
);
  import dlmb_pkg::*;

  elem_t            q_mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wp;
  logic [OQ_AW-1:0] rp;
  logic             pop;

  assign head_valid = (count != '0);
  assign head_elem  = q_mem[rp];
  assign pop        = head_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp] <= push_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + OQ_AW'(1);
      end
      if (pop) begin
        rp <= rp + OQ_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (OQ_AW+1)'(1);
      end else if (!push && pop) begin
        count <= count - (OQ_AW+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < (OQ_AW+1)'(OQ_DEPTH)))
    else $error("result queue overflow");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == (OQ_AW+1)'($past(count) + (OQ_AW+1)'(1))))
    else $error("result queue count did not advance");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (!push && pop) |=> (count == (OQ_AW+1)'($past(count) - (OQ_AW+1)'(1))))
    else $error("result queue count did not drop");

endmodule

>>> rtl/decimated_lag_matrix_builder_core.sv
// channel   dir  handshake        payload
// apb       in   psel/penable     paddr, pwdata -> prdata (pready tied high)
// s_axis    in   tvalid/tready    tuser: command; tdata: sample, lag_slot, lag_amount
// m_axis    out  tvalid/tready    tdata: row_index, column_index, value; tuser: missing;
//                                 tlast: row_last
// A sample or padding transaction takes the sequencer through PREP and DECIDE; when a row
// of n columns goes out it also passes through EMIT, one history read per column. Lag
// writes and restarts stay in IDLE. The single history read port sets the column rate.
// Reset is synchronous; the history memory is not cleared, no sweep follows reset.
// Results queue in a 4-entry buffer; a stalled master side pauses column reads and input.
module decimated_lag_matrix_builder_core #(
  parameter int HISTORY_DEPTH = 1024,
  parameter int MAX_LAGS      = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dlmb_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [dlmb_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [dlmb_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [dlmb_pkg::IN_DATA_W-1:0]     s_tdata,   // sample, lag_slot, lag_amount, pad
  input  logic [dlmb_pkg::CMD_W-1:0]         s_tuser,   // command
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [dlmb_pkg::OUT_DATA_W-1:0]    m_tdata,   // row_index, column_index, value, pad
  output logic [dlmb_pkg::OUT_USER_W-1:0]    m_tuser,   // missing
  output logic                               m_tlast
);
  import dlmb_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic [DEC_W-1:0]  decimation;
  logic [OFS_W-1:0]  row_offset;
  logic [LCNT_W-1:0] lag_count;
  logic              cfg_wr;

  cmd_t                     cmd;
  logic [SAMPLE_W-1:0]      in_sample;
  logic [SLOT_W-1:0]        in_slot;
  logic signed [LAG_W-1:0]  in_lag;
  logic                     in_acc;

  state_t state;
  state_t state_next;

  logic signed [LAG_W-1:0] lag_tab [MAX_LAGS];
  logic [CNT_W-1:0]        sample_counter;
  logic [AW-1:0]           wr_ptr;
  logic [ROW_W-1:0]        next_row;
  logic [CNT_W-1:0]        next_row_base;
  logic [CNT_W-1:0]        stream_length;
  logic                    stream_ended;
  logic                    store;

  logic [LCNT_W-1:0]       ncols;
  logic [LAG_W-1:0]        lead_max;
  logic [LCNT_W-1:0]       ncols_r;
  logic [LAG_W-1:0]        lead_r;
  logic [BASE_W-1:0]       base_r;
  logic signed [IDX_W-1:0] cb_r;
  logic [ROW_W-1:0]        row_r;

  logic [BASE_W:0]         latest;
  logic                    row_go;
  logic [DEC_W-1:0]        step;
  logic [BASE_W-1:0]       nb;

  logic [COL_W-1:0]        col;
  logic signed [LAG_W-1:0] lag_sel;
  logic signed [IDX_W-1:0] lag_ext;
  logic [OQ_AW:0]          oq_count;
  logic [OQ_AW:0]          credit_sum;
  logic                    issue;
  logic                    issue_last;

  logic                    s1_valid;
  logic [COL_W-1:0]        s1_col;
  logic                    s1_last;
  logic signed [IDX_W-1:0] s1_dist;
  logic                    s1_neg;

  logic                    s2_valid;
  logic [COL_W-1:0]        s2_col;
  logic                    s2_last;
  logic                    s2_miss;

  logic                    miss_b;
  logic [AW:0]             rd_tmp;
  logic [AW-1:0]           rd_addr;
  logic [SAMPLE_W-1:0]     rd_data;

  elem_t                   push_elem;
  elem_t                   head_elem;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation <= DEC_W'(1);
      row_offset <= '0;
      lag_count  <= LCNT_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[APB_ADDR_W-1:2])
        REG_DECIMATION: decimation <= pwdata[DEC_W-1:0];
        REG_ROW_OFFSET: row_offset <= pwdata[OFS_W-1:0];
        REG_LAG_COUNT:  lag_count  <= pwdata[LCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[APB_ADDR_W-1:2])
      REG_DECIMATION: prdata = APB_DATA_W'(decimation);
      REG_ROW_OFFSET: prdata = APB_DATA_W'(row_offset);
      REG_LAG_COUNT:  prdata = APB_DATA_W'(lag_count);
      default:        prdata = '0;
    endcase
  end

  // input unpack
  assign cmd       = cmd_t'(s_tuser);
  assign in_sample = s_tdata[SAMPLE_W-1:0];
  assign in_slot   = s_tdata[SAMPLE_W+SLOT_W-1:SAMPLE_W];
  assign in_lag    = s_tdata[SAMPLE_W+SLOT_W+LAG_W-1:SAMPLE_W+SLOT_W];

  assign s_tready = (state == ST_IDLE) & ~s1_valid;
  assign in_acc   = s_tvalid & s_tready;
  assign store    = in_acc & (cmd == CMD_SAMPLE) & ~stream_ended & (sample_counter != '1);

  // stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
      wr_ptr         <= '0;
      next_row       <= '0;
      next_row_base  <= '0;
      stream_length  <= '0;
      stream_ended   <= 1'b0;
    end else if (in_acc && cmd == CMD_RESTART) begin
      sample_counter <= '0;
      wr_ptr         <= '0;
      next_row       <= '0;
      next_row_base  <= '0;
      stream_length  <= '0;
      stream_ended   <= 1'b0;
    end else begin
      if (store) begin
        sample_counter <= sample_counter + CNT_W'(1);
        wr_ptr <= (wr_ptr == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (in_acc && cmd == CMD_PAD && !stream_ended) begin
        stream_ended  <= 1'b1;
        stream_length <= sample_counter;
      end
      if (state == ST_DECIDE && row_go) begin
        next_row      <= next_row + ROW_W'(1);
        next_row_base <= nb[BASE_W-1] ? '1 : nb[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_LAGS; k++) begin
        lag_tab[k] <= '0;
      end
    end else if (in_acc && cmd == CMD_LAG) begin
      for (int k = 0; k < MAX_LAGS; k++) begin
        if (in_slot == SLOT_W'(k)) begin
          lag_tab[k] <= in_lag;
        end
      end
    end
  end

  // row preparation
  always_comb begin
    if (lag_count == '0) begin
      ncols = LCNT_W'(1);
    end else if (lag_count > LCNT_W'(MAX_LAGS)) begin
      ncols = LCNT_W'(MAX_LAGS);
    end else begin
      ncols = lag_count;
    end
  end

  always_comb begin
    logic signed [LAG_W:0] lead;
    lead     = '0;
    lead_max = '0;
    for (int k = 0; k < MAX_LAGS; k++) begin
      lead = -{lag_tab[k][LAG_W-1], lag_tab[k]};
      if ((LCNT_W'(k) < ncols) && (lead > $signed({1'b0, lead_max}))) begin
        lead_max = lead[LAG_W-1:0];
      end
    end
  end

  assign latest = {1'b0, base_r} + (BASE_W+1)'(lead_r);
  assign row_go = stream_ended ? (base_r < {1'b0, stream_length})
                               : (latest < (BASE_W+1)'(sample_counter));
  assign step   = (decimation == '0) ? DEC_W'(1) : decimation;
  assign nb     = {1'b0, next_row_base} + BASE_W'(step);

  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      base_r  <= {1'b0, next_row_base} + BASE_W'(row_offset);
      lead_r  <= lead_max;
      ncols_r <= ncols;
    end
    if (state == ST_DECIDE) begin
      cb_r  <= IDX_W'(sample_counter) - IDX_W'(base_r);
      row_r <= next_row;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_acc && (cmd inside {CMD_SAMPLE, CMD_PAD})) state_next = ST_PREP;
      ST_PREP:   state_next = ST_DECIDE;
      ST_DECIDE: state_next = row_go ? ST_EMIT : ST_IDLE;
      ST_EMIT:   if (issue && issue_last) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // column issue
  always_comb begin
    lag_sel = '0;
    for (int k = 0; k < MAX_LAGS; k++) begin
      if (col == COL_W'(k)) begin
        lag_sel = lag_tab[k];
      end
    end
  end

  assign lag_ext    = IDX_W'(lag_sel);
  assign credit_sum = oq_count + (OQ_AW+1)'(s1_valid) + (OQ_AW+1)'(s2_valid);
  assign issue      = (state == ST_EMIT) && (credit_sum < (OQ_AW+1)'(OQ_DEPTH));
  assign issue_last = (LCNT_W'(col) + LCNT_W'(1) == ncols_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (state == ST_DECIDE) begin
        col <= '0;
      end else if (issue) begin
        col <= col + COL_W'(1);
      end
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_col  <= col;
      s1_last <= issue_last;
      s1_dist <= cb_r + lag_ext;
      s1_neg  <= lag_ext > $signed(IDX_W'(base_r));
    end
    if (s1_valid) begin
      s2_col  <= s1_col;
      s2_last <= s1_last;
      s2_miss <= miss_b;
    end
  end

  // history read address
  assign miss_b  = s1_neg || (s1_dist < $signed(IDX_W'(1)))
                   || (s1_dist > $signed(IDX_W'(HISTORY_DEPTH)));
  assign rd_tmp  = {1'b0, wr_ptr} + (AW+1)'(HISTORY_DEPTH) - s1_dist[AW:0];
  assign rd_addr = (rd_tmp >= (AW+1)'(HISTORY_DEPTH)) ?
                   AW'(rd_tmp - (AW+1)'(HISTORY_DEPTH)) : rd_tmp[AW-1:0];

  dlmb_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk  (clk),
    .we   (store),
    .waddr(wr_ptr),
    .wdata(in_sample),
    .re   (s1_valid),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // result queue
  always_comb begin
    push_elem.row_index    = row_r;
    push_elem.column_index = s2_col;
    push_elem.value        = s2_miss ? '0 : rd_data;
    push_elem.missing      = s2_miss;
    push_elem.row_last     = s2_last;
  end

  dlmb_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_elem (push_elem),
    .pop_ready (m_tready),
    .head_valid(m_tvalid),
    .head_elem (head_elem),
    .count     (oq_count)
  );

  assign m_tdata = {(OUT_DATA_W - ROW_W - COL_W - SAMPLE_W)'(0), head_elem.value,
                    head_elem.column_index, head_elem.row_index};
  assign m_tuser = head_elem.missing;
  assign m_tlast = head_elem.row_last;

  a_no_write_during_read: assert property (@(posedge clk) disable iff (rst)
    store |-> !s1_valid)
    else $error("history write collides with pending read");

  a_last_column_ends_row: assert property (@(posedge clk) disable iff (rst)
    (issue && issue_last) |=> (state == ST_IDLE && s1_valid && s1_last))
    else $error("row did not close after its last column");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit_sum <= (OQ_AW+1)'(OQ_DEPTH))
    else $error("more columns in flight than queue space");

  a_row_advance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && row_go) |=> (next_row == ROW_W'($past(next_row) + ROW_W'(1))))
    else $error("row number did not advance on release");

endmodule

>>> tb/sv/decimated_lag_matrix_builder_core_tb.sv
module decimated_lag_matrix_builder_core_tb;
  import dlmb_pkg::*;

  localparam int HIST_DEPTH  = 1024;
  localparam int LAG_SLOTS   = 8;
  localparam int RAND_ITEMS  = 500;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_GAP    = 24;
  localparam int DRAIN_GAP   = 40;
  localparam int CYCLE_LIMIT = 600000;

  typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

  typedef struct {
    step_kind_t              kind;
    cmd_t                    cmd;
    logic [SAMPLE_W-1:0]     smp;
    logic [SLOT_W-1:0]       slot;
    logic signed [LAG_W-1:0] amt;
    logic [REG_IDX_W-1:0]    reg_idx;
    logic [APB_DATA_W-1:0]   reg_val;
    int                      n_typed;
    elem_t                   typed;
  } step_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata = '0;   // sample, lag_slot, lag_amount, pad
  logic [CMD_W-1:0]        s_tuser = '0;   // command
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;        // row_index, column_index, value, pad
  logic [OUT_USER_W-1:0]   m_tuser;        // missing
  logic                    m_tlast;

  decimated_lag_matrix_builder_core dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always #2 clk = ~clk;

  // matrix state mirror
  logic [SAMPLE_W-1:0]     hist_mem [HIST_DEPTH];
  logic signed [LAG_W-1:0] lag_tab [LAG_SLOTS];
  bit [CNT_W-1:0]          samples_seen;
  bit [ROW_W-1:0]          row_num;
  bit [CNT_W-1:0]          row_base;
  bit [CNT_W-1:0]          end_len;
  bit                      ended;
  bit [DEC_W-1:0]          dec_reg;
  bit [OFS_W-1:0]          ofs_reg;
  bit [LCNT_W-1:0]         lcnt_reg;

  elem_t pending_elems [$];
  elem_t fresh_elems [$];
  step_t directed_steps [$];

  int  errors;
  int  items_sent;
  int  results_seen;
  int  phase_no;
  int  burst_left;
  int  cycles;
  bit  hold_req;
  bit  hold_done;
  int  hold_left;
  int  stretch_left;
  int  rx_mode;

  function automatic void clear_stream();
    samples_seen = '0;
    row_num = '0;
    row_base = '0;
    end_len = '0;
    ended = 1'b0;
  endfunction

  function automatic void predict_row_elements(cmd_t cmd, logic [SAMPLE_W-1:0] smp,
                                               logic [SLOT_W-1:0] slot,
                                               logic signed [LAG_W-1:0] amt);
    longint base, latest, idx, cnt, nb, stride;
    int     ncols, j;
    bit     miss;
    elem_t  e;
    fresh_elems.delete();
    case (cmd)
      CMD_LAG: begin
        lag_tab[slot] = amt;
        return;
      end
      CMD_RESTART: begin
        clear_stream();
        return;
      end
      CMD_SAMPLE: begin
        if (!ended && samples_seen != '1) begin
          hist_mem[samples_seen[9:0]] = smp;
          samples_seen++;
        end
      end
      default: begin
        if (!ended) begin
          ended = 1'b1;
          end_len = samples_seen;
        end
      end
    endcase
    ncols = (lcnt_reg == 0) ? 1 : (lcnt_reg > LAG_SLOTS) ? LAG_SLOTS : int'(lcnt_reg);
    stride = (dec_reg == 0) ? 1 : longint'(dec_reg);
    cnt = longint'(samples_seen);
    base = longint'(row_base) + longint'(ofs_reg);
    latest = base;
    for (j = 0; j < ncols; j++) begin
      idx = base - longint'(lag_tab[j]);
      if (idx > latest) latest = idx;
    end
    if (ended) begin
      if (base >= longint'(end_len)) return;
    end else if (latest >= cnt) begin
      return;
    end
    for (j = 0; j < ncols; j++) begin
      idx = base - longint'(lag_tab[j]);
      miss = idx < 0 || idx >= cnt || cnt - idx > HIST_DEPTH;
      e.row_index = row_num;
      e.column_index = j[COL_W-1:0];
      e.value = miss ? '0 : hist_mem[idx[9:0]];
      e.missing = miss;
      e.row_last = (j + 1 == ncols);
      fresh_elems.push_back(e);
    end
    row_num++;
    nb = longint'(row_base) + stride;
    row_base = (nb > 64'hFFFF_FFFF) ? '1 : nb[CNT_W-1:0];
  endfunction

  function automatic void add_item(cmd_t cmd, logic [SAMPLE_W-1:0] smp, logic [SLOT_W-1:0] slot,
                                   logic signed [LAG_W-1:0] amt, int n_typed, elem_t typed);
    step_t s;
    s.kind = STEP_ITEM;
    s.cmd = cmd;
    s.smp = smp;
    s.slot = slot;
    s.amt = amt;
    s.reg_idx = '0;
    s.reg_val = '0;
    s.n_typed = n_typed;
    s.typed = typed;
    directed_steps.push_back(s);
  endfunction

  function automatic void add_cfg(logic [REG_IDX_W-1:0] reg_idx, logic [APB_DATA_W-1:0] val);
    step_t s;
    s.kind = STEP_CFG;
    s.cmd = CMD_SAMPLE;
    s.smp = '0;
    s.slot = '0;
    s.amt = '0;
    s.reg_idx = reg_idx;
    s.reg_val = val;
    s.n_typed = 0;
    s.typed = '0;
    directed_steps.push_back(s);
  endfunction

  task automatic send_item(cmd_t cmd, logic [SAMPLE_W-1:0] smp, logic [SLOT_W-1:0] slot,
                           logic signed [LAG_W-1:0] amt, int n_typed, elem_t typed);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {2'b00, amt, slot, smp};
    do @(posedge clk); while (!s_tready);
    predict_row_elements(cmd, smp, slot, amt);
    if (n_typed < 0) begin
      foreach (fresh_elems[k]) pending_elems.push_back(fresh_elems[k]);
    end else if (n_typed > 0) begin
      pending_elems.push_back(typed);
    end
    items_sent++;
  endtask

  task automatic send_sample();
    send_item(CMD_SAMPLE, $urandom, '0, '0, -1, '0);
  endtask

  task automatic send_lag(logic [SLOT_W-1:0] slot, int amt);
    send_item(CMD_LAG, $urandom, slot, amt[LAG_W-1:0], -1, '0);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic apb_write(logic [REG_IDX_W-1:0] reg_idx, logic [APB_DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (reg_idx)
      REG_DECIMATION: dec_reg = val[DEC_W-1:0];
      REG_ROW_OFFSET: ofs_reg = val[OFS_W-1:0];
      REG_LAG_COUNT:  lcnt_reg = val[LCNT_W-1:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_req && !hold_done && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      if (stretch_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        stretch_left <= $urandom_range(5, 60);
      end else begin
        stretch_left <= stretch_left - 1;
      end
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 4) == 0);
        default: m_tready <= cycles[1];
      endcase
    end
  end

  always @(posedge clk) begin
    elem_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[23:0], m_tdata[26:24], m_tdata[58:27], m_tuser[0], m_tlast};
      results_seen++;
      if (pending_elems.size() == 0) begin
        if (errors < 10)
          $display("unexpected element: row %0d col %0d value %h missing %0d last %0d",
                   got.row_index, got.column_index, got.value, got.missing, got.row_last);
        errors++;
      end else begin
        want = pending_elems.pop_front();
        if (got !== want) begin
          if (errors < 10)
            $display({"mismatch: expected row %0d col %0d value %h missing %0d last %0d,",
                      " got row %0d col %0d value %h missing %0d last %0d"},
                     want.row_index, want.column_index, want.value, want.missing,
                     want.row_last, got.row_index, got.column_index, got.value,
                     got.missing, got.row_last);
          errors++;
        end
      end
    end
  end

  initial begin
    int len, n, a, v;
    lag_tab = '{default: '0};
    clear_stream();
    dec_reg = 1;
    ofs_reg = 0;
    lcnt_reg = 1;

    add_item(CMD_SAMPLE, 32'h7FFF_FFFF, 3'd0, 11'sd0, 1, '{24'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 1'b1});
    add_item(CMD_SAMPLE, 32'h8000_0000, 3'd0, 11'sd0, 1, '{24'd1, 3'd0, 32'h8000_0000, 1'b0, 1'b1});
    add_item(CMD_SAMPLE, 32'h0000_0000, 3'd0, 11'sd0, 1, '{24'd2, 3'd0, 32'h0000_0000, 1'b0, 1'b1});
    add_item(CMD_SAMPLE, 32'hFFFF_FFFF, 3'd0, 11'sd0, 1, '{24'd3, 3'd0, 32'hFFFF_FFFF, 1'b0, 1'b1});
    add_item(CMD_PAD, 32'h0, 3'd0, 11'sd0, 0, '0);
    add_item(CMD_PAD, 32'h0, 3'd0, 11'sd0, 0, '0);
    add_item(CMD_SAMPLE, 32'h1234_5678, 3'd0, 11'sd0, 0, '0);
    add_item(CMD_RESTART, 32'h0, 3'd0, 11'sd0, 0, '0);
    add_item(CMD_LAG, 32'h0, 3'd0, 11'sd1023, 0, '0);
    add_item(CMD_LAG, 32'h0, 3'd1, -11'sd1023, 0, '0);
    add_item(CMD_LAG, 32'h0, 3'd7, -11'sd1, 0, '0);
    add_cfg(REG_LAG_COUNT, 32'd0);
    add_item(CMD_SAMPLE, 32'h5A5A_5A5A, 3'd0, 11'sd0, 1, '{24'd0, 3'd0, 32'h0, 1'b1, 1'b1});
    add_cfg(REG_LAG_COUNT, 32'd15);
    add_item(CMD_SAMPLE, 32'hC3C3_C3C3, 3'd0, 11'sd0, -1, '0);
    add_item(CMD_PAD, 32'h0, 3'd0, 11'sd0, -1, '0);
    add_item(CMD_PAD, 32'h0, 3'd0, 11'sd0, 0, '0);
    add_item(CMD_RESTART, 32'h0, 3'd0, 11'sd0, 0, '0);
    add_cfg(REG_DECIMATION, 32'd0);
    add_item(CMD_SAMPLE, 32'h0F0F_0F0F, 3'd0, 11'sd0, -1, '0);
    add_item(CMD_PAD, 32'h0, 3'd0, 11'sd0, -1, '0);
    add_cfg(REG_ROW_OFFSET, 32'd65535);
    add_cfg(REG_DECIMATION, 32'd1024);
    add_item(CMD_RESTART, 32'h0, 3'd0, 11'sd0, 0, '0);
    add_item(CMD_SAMPLE, 32'h6996_6996, 3'd0, 11'sd0, -1, '0);
    add_item(CMD_PAD, 32'h0, 3'd0, 11'sd0, -1, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_CFG) begin
        wait_idle();
        apb_write(directed_steps[i].reg_idx, directed_steps[i].reg_val);
      end else begin
        send_item(directed_steps[i].cmd, directed_steps[i].smp, directed_steps[i].slot,
                  directed_steps[i].amt, directed_steps[i].n_typed, directed_steps[i].typed);
      end
    end

    while (items_sent < RAND_ITEMS + directed_steps.size()) begin
      wait_idle();
      if (phase_no == 0) begin
        apb_write(REG_DECIMATION, 32'd1);
        apb_write(REG_ROW_OFFSET, 32'd0);
        apb_write(REG_LAG_COUNT, 32'd8);
        for (int k = 0; k < LAG_SLOTS; k++) send_lag(3'(k), k);
        hold_req = 1'b1;
      end else begin
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 5))
            0: v = 0;
            1: v = 1024;
            2, 3: v = 1;
            default: v = $urandom_range(2, 9);
          endcase
          apb_write(REG_DECIMATION, v);
        end
        if ($urandom_range(0, 1))
          apb_write(REG_ROW_OFFSET, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 24));
        if ($urandom_range(0, 1))
          apb_write(REG_LAG_COUNT, $urandom_range(0, 15));
      end
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 7))
          0: a = 1023;
          1: a = -1023;
          2: a = int'($urandom_range(0, 2046)) - 1023;
          default: a = int'($urandom_range(0, 12)) - 6;
        endcase
        send_lag(3'($urandom_range(0, 7)), a);
      end
      if ($urandom_range(0, 3) != 0)
        send_item(CMD_RESTART, $urandom, '0, '0, -1, '0);
      len = $urandom_range(4, 50);
      repeat (len) begin
        if ($urandom_range(0, 15) == 0) begin
          case ($urandom_range(0, 2))
            0: send_item(CMD_PAD, $urandom, '0, '0, -1, '0);
            1: send_lag(3'($urandom_range(0, 7)), int'($urandom_range(0, 8)) - 4);
            default: send_item(CMD_RESTART, $urandom, '0, '0, -1, '0);
          endcase
        end else begin
          send_sample();
        end
      end
      n = $urandom_range(0, 12);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) send_sample();
        else send_item(CMD_PAD, $urandom, '0, '0, -1, '0);
      end
      phase_no++;
    end

    s_tvalid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
    $display("Sent %0d input transactions in %0d stream phases; checked %0d row elements.",
             items_sent, phase_no, results_seen);
    $display("Included a %0d-cycle output hold with the input backed up; %0d errors.",
             HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
